### design/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int unsigned ROUNDS    = 80;
	localparam int unsigned RND_W     = $clog2(ROUNDS);
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned BLK_BYTES = 64;
	localparam int unsigned POS_W     = $clog2(BLK_BYTES);
	localparam int unsigned OUT_WORDS = 5;
	localparam int unsigned IDX_W     = 3;

	localparam logic [POS_W-1:0] BLOCK_LAST = POS_W'(BLK_BYTES - 1);
	localparam logic [POS_W-1:0] LEN_BYTE   = POS_W'(56);
	localparam logic [7:0]       PAD_BYTE   = 8'h80;

	localparam logic [31:0] INIT_H [OUT_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] K_0 = 32'h5a827999;
	localparam logic [31:0] K_1 = 32'h6ed9eba1;
	localparam logic [31:0] K_2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_3 = 32'hca62c1d6;

	typedef struct packed {
		logic append;     // write one message byte, count 8 bits
		logic pad;        // write 0x80 at position, clear the rest of the block
		logic comp_start; // load working words, restart round counter
		logic round;      // one compression round
		logic fold;       // add working words into chaining words
		logic put_len;    // write bit length into the last two words
		logic clear_pad;  // with put_len: clear words ahead of the length
		logic finish_out; // fold into output buffer, return to initial state
	} sha1_cmd_t;

	typedef struct packed {
		logic block_full;
		logic long_pad;
		logic round_last;
		logic out_busy;
	} sha1_status_t;

	function automatic logic [31:0] sha1_f(input logic [RND_W-1:0] rnd,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < RND_W'(20)) begin
			f = (b & c) | (~b & d);
		end else if (rnd < RND_W'(40)) begin
			f = b ^ c ^ d;
		end else if (rnd < RND_W'(60)) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic logic [31:0] sha1_k(input logic [RND_W-1:0] rnd);
		logic [31:0] k;
		if (rnd < RND_W'(20)) begin
			k = K_0;
		end else if (rnd < RND_W'(40)) begin
			k = K_1;
		end else if (rnd < RND_W'(60)) begin
			k = K_2;
		end else begin
			k = K_3;
		end
		return k;
	endfunction

endpackage

### design/sha1_datapath.sv
// ----------------------------------------------------------------------------
// sha1_datapath
// Block buffer with rolling message schedule, bit counter, round unit,
// chaining words and the digest output buffer.
// ----------------------------------------------------------------------------
module sha1_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha1_pkg::sha1_cmd_t    cmd,
	output sha1_pkg::sha1_status_t status,
	input  logic [7:0]             data_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            digest_word,
	output logic [2:0]             word_index,
	output logic                   last
);
	import sha1_pkg::*;

	logic [31:0]      chain_q [OUT_WORDS];
	logic [31:0]      work_q  [OUT_WORDS];
	logic [31:0]      work_d  [OUT_WORDS];
	logic [31:0]      sum     [OUT_WORDS];
	logic [31:0]      buf_q   [BLK_WORDS];
	logic [31:0]      buf_d   [BLK_WORDS];
	logic [31:0]      out_words_q [OUT_WORDS];
	logic [63:0]      cnt_q;
	logic [RND_W-1:0] round_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_valid_q;
	logic [POS_W-1:0] pos;
	logic [31:0]      w_new;
	logic [31:0]      t_sum;

	assign pos = cnt_q[POS_W+2:3];

	assign status.block_full = (pos == BLOCK_LAST);
	assign status.long_pad   = (pos >= LEN_BYTE);
	assign status.round_last = (round_q == RND_W'(ROUNDS - 1));
	assign status.out_busy   = out_valid_q;

	// rolling 16-word schedule window, word 0 is the current round's word
	assign w_new = buf_q[13] ^ buf_q[8] ^ buf_q[2] ^ buf_q[0];

	assign t_sum = {work_q[0][26:0], work_q[0][31:27]}
		+ sha1_f(round_q, work_q[1], work_q[2], work_q[3])
		+ work_q[4] + buf_q[0] + sha1_k(round_q);

	always_comb begin
		work_d[0] = t_sum;
		work_d[1] = work_q[0];
		work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
		work_d[3] = work_q[2];
		work_d[4] = work_q[3];
		for (int i = 0; i < OUT_WORDS; i++) begin
			sum[i] = chain_q[i] + work_q[i];
		end
	end

	always_comb begin
		buf_d = buf_q;
		if (cmd.round) begin
			for (int w = 0; w < BLK_WORDS - 1; w++) begin
				buf_d[w] = buf_q[w+1];
			end
			buf_d[BLK_WORDS-1] = {w_new[30:0], w_new[31]};
		end
		// byte l of word w sits big-endian in the word
		for (int w = 0; w < BLK_WORDS; w++) begin
			for (int l = 0; l < 4; l++) begin
				if (cmd.append && POS_W'(w * 4 + l) == pos) begin
					buf_d[w][(3-l)*8 +: 8] = data_byte;
				end
				if (cmd.pad) begin
					if (POS_W'(w * 4 + l) == pos) begin
						buf_d[w][(3-l)*8 +: 8] = PAD_BYTE;
					end else if (POS_W'(w * 4 + l) > pos) begin
						buf_d[w][(3-l)*8 +: 8] = 8'h00;
					end
				end
			end
		end
		if (cmd.put_len) begin
			if (cmd.clear_pad) begin
				for (int w = 0; w < BLK_WORDS - 2; w++) begin
					buf_d[w] = 32'h0;
				end
			end
			buf_d[BLK_WORDS-2] = cnt_q[63:32];
			buf_d[BLK_WORDS-1] = cnt_q[31:0];
		end
	end

	always_ff @(posedge clk) begin
		buf_q <= buf_d;
		if (cmd.comp_start) begin
			work_q <= chain_q;
		end else if (cmd.round) begin
			work_q <= work_d;
		end
		if (cmd.finish_out) begin
			out_words_q <= sum;
		end else if (out_valid_q && out_ready) begin
			for (int i = 0; i < OUT_WORDS - 1; i++) begin
				out_words_q[i] <= out_words_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q     <= INIT_H;
			cnt_q       <= '0;
			round_q     <= '0;
			out_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				cnt_q <= cnt_q + 64'd8;
			end
			if (cmd.comp_start) begin
				round_q <= '0;
			end else if (cmd.round) begin
				round_q <= round_q + RND_W'(1);
			end
			if (cmd.fold) begin
				chain_q <= sum;
			end
			if (cmd.finish_out) begin
				chain_q     <= INIT_H;
				cnt_q       <= '0;
				out_idx_q   <= '0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_idx_q <= out_idx_q + IDX_W'(1);
				if (out_idx_q == IDX_W'(OUT_WORDS - 1)) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = out_words_q[0];
	assign word_index  = out_idx_q;
	assign last        = (out_idx_q == IDX_W'(OUT_WORDS - 1));

endmodule

### design/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer for byte appends, block compression and final padding.
// ----------------------------------------------------------------------------
module sha1_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_kind,
	output logic                   in_ready,
	input  sha1_pkg::sha1_status_t status,
	output sha1_pkg::sha1_cmd_t    cmd
);
	import sha1_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROUND,
		S_LEN,
		S_FOLD
	} state_t;

	state_t state_q;
	logic   fin_q;
	logic   extra_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!in_kind) begin
						cmd.append     = 1'b1;
						cmd.comp_start = status.block_full;
					end else begin
						cmd.pad        = 1'b1;
						cmd.comp_start = status.long_pad;
					end
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
			end
			S_LEN: begin
				cmd.put_len    = 1'b1;
				cmd.clear_pad  = extra_q;
				cmd.comp_start = 1'b1;
			end
			S_FOLD: begin
				if (!fin_q || extra_q) begin
					cmd.fold = 1'b1;
				end else begin
					cmd.finish_out = !status.out_busy;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= 1'b0;
			extra_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!in_kind) begin
							if (status.block_full) begin
								state_q <= S_ROUND;
							end
						end else begin
							fin_q <= 1'b1;
							// no room for the length: pad out this block first
							if (status.long_pad) begin
								extra_q <= 1'b1;
								state_q <= S_ROUND;
							end else begin
								state_q <= S_LEN;
							end
						end
					end
				end
				S_ROUND: begin
					if (status.round_last) begin
						state_q <= S_FOLD;
					end
				end
				S_LEN: begin
					extra_q <= 1'b0;
					state_q <= S_ROUND;
				end
				S_FOLD: begin
					if (!fin_q) begin
						state_q <= S_IDLE;
					end else if (extra_q) begin
						state_q <= S_LEN;
					end else if (!status.out_busy) begin
						fin_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 over a byte stream: append bytes, then finish to get the digest.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_*     | in        | tuser = kind, tdata = data_byte
//  m_*     | out       | tdata = digest_word, word_index; tlast = last
//
//  an append is taken while idle; the byte that fills a block then starts a compression
//  (the rounds of one shared round unit, then the fold into the chaining words)
//  a finish pads, writes the length and compresses; an extra block comes first if needed
//  the five digest words sit in an output buffer and drain on m_tready while
//  new bytes are taken; a finish waits only if the previous digest is still there
//  after reset the engine is at the initial hash state with an empty message
module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_tlast
);
	import sha1_pkg::*;

	sha1_cmd_t    cmd;
	sha1_status_t status;
	logic [31:0]  digest_word;
	logic [2:0]   word_index;

	sha1_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sha1_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.data_byte   (s_tdata),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last        (m_tlast)
	);

	assign m_tdata = {5'b0, word_index, digest_word};

endmodule

### tb/sv/tb_sha1_hash_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_hash_engine
// Self-checking bench for the SHA-1 byte stream engine. Messages of random
// content are streamed in, short and one needing an extra length block, and
// each digest word is compared with an in-bench SHA-1 computation. Both
// sides of the stream idle at random, and one long output stall fills the
// engine until it holds off its input.
// ----------------------------------------------------------------------------
module tb_sha1_hash_engine;

	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 400;
	localparam int HOLD_CYCLES  = 1500;
	localparam int RANDOM_ITEMS = 28;

	typedef struct {
		logic [31:0]                  word;
		logic [sha1_pkg::IDX_W-1:0]   idx;
		logic                         last;
	} digest_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index
	logic        m_tlast;

	// software copy of the hash state
	logic [31:0] hash_h [sha1_pkg::OUT_WORDS];
	logic [31:0] msg_blk [16];
	logic [63:0] msg_bits;

	digest_word_t digest_q [$];

	int errors      = 0;
	int items_sent  = 0;
	int cycle_cnt   = 0;
	int rx_hold     = 0;
	bit tx_calm     = 1'b0;
	bit rx_calm     = 1'b0;

	sha1_hash_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void hash_restart();
		hash_h[0] = 32'h67452301;
		hash_h[1] = 32'hefcdab89;
		hash_h[2] = 32'h98badcfe;
		hash_h[3] = 32'h10325476;
		hash_h[4] = 32'hc3d2e1f0;
		msg_bits  = 64'd0;
	endfunction

	// bytes sit big-endian within each block word
	function automatic void put_msg_byte(input int pos, input logic [7:0] b);
		int w;
		int sh;
		w = (pos >> 2) & 15;
		sh = (3 - (pos & 3)) * 8;
		msg_blk[w][sh +: 8] = b;
	endfunction

	function automatic void sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) w[i] = msg_blk[i];
		for (int i = 16; i < 80; i++)
			w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hash_h[0];
		b = hash_h[1];
		c = hash_h[2];
		d = hash_h[3];
		e = hash_h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5a827999;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ed9eba1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8f1bbcdc;
			end else begin
				f = b ^ c ^ d;
				k = 32'hca62c1d6;
			end
			t = rol32(a, 5) + f + e + w[i] + k;
			e = d;
			d = c;
			c = rol32(b, 30);
			b = a;
			a = t;
		end
		hash_h[0] += a;
		hash_h[1] += b;
		hash_h[2] += c;
		hash_h[3] += d;
		hash_h[4] += e;
	endfunction

	// advance the hash state by one accepted transaction
	function automatic void predict_digest(input logic knd, input logic [7:0] b);
		int pos;
		digest_word_t dw;
		pos = int'(msg_bits[8:3]);
		if (knd == KIND_APPEND) begin
			put_msg_byte(pos, b);
			msg_bits += 64'd8;
			if (pos == 63) sha1_compress();
		end else begin
			put_msg_byte(pos, 8'h80);
			pos++;
			// no room for the length: pad out and compress an extra block
			if (pos > 56) begin
				for (int i = pos; i < 64; i++) put_msg_byte(i, 8'h00);
				sha1_compress();
				pos = 0;
			end
			for (int i = pos; i < 56; i++) put_msg_byte(i, 8'h00);
			msg_blk[14] = msg_bits[63:32];
			msg_blk[15] = msg_bits[31:0];
			sha1_compress();
			for (int i = 0; i < sha1_pkg::OUT_WORDS; i++) begin
				dw.word = hash_h[i];
				dw.idx  = sha1_pkg::IDX_W'(i);
				dw.last = (i == sha1_pkg::OUT_WORDS - 1);
				digest_q.push_back(dw);
			end
			hash_restart();
		end
	endfunction

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 16));
	endfunction

	task automatic send_item(input logic knd, input logic [7:0] b);
		int gap;
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= knd;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_digest(knd, b);
		items_sent++;
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) send_item(KIND_APPEND, 8'($urandom_range(0, 255)));
		send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_for_digests();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (digest_q.size() != 0) @(posedge clk);
	endtask

	// output side: random hold-offs per word, plus a long stall on request
	initial begin
		int gap;
		digest_word_t exp_w;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(rx_calm) + rx_hold;
			rx_hold = 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest transaction, actual word %h index %0d last %b",
					$time, m_tdata[31:0], m_tdata[34:32], m_tlast);
				errors++;
			end else begin
				exp_w = digest_q.pop_front();
				if (m_tdata[31:0] !== exp_w.word) begin
					$display("%0t: digest_word mismatch, expected %h actual %h",
						$time, exp_w.word, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[34:32] !== exp_w.idx) begin
					$display("%0t: word_index mismatch, expected %0d actual %0d",
						$time, exp_w.idx, m_tdata[34:32]);
					errors++;
				end
				if (m_tlast !== exp_w.last) begin
					$display("%0t: last mismatch, expected %b actual %b",
						$time, exp_w.last, m_tlast);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		// empty message, data ignored on finish
		send_item(KIND_FINISH, 8'hff);
		send_item(KIND_APPEND, 8'h61);
		send_item(KIND_APPEND, 8'h62);
		send_item(KIND_APPEND, 8'h63);
		send_item(KIND_FINISH, 8'h00);
		send_item(KIND_APPEND, 8'h00);
		send_item(KIND_APPEND, 8'hff);
		send_item(KIND_FINISH, 8'h5a);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		send_item(KIND_APPEND, 8'h80);
		send_item(KIND_FINISH, 8'ha5);
		send_item(KIND_APPEND, 8'hff);
		send_item(KIND_FINISH, 8'hff);
		wait_for_digests();
	endtask

	// a full block from appends, then the length spills into an extra block
	task automatic test_pad_boundaries();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		send_message(120);
		wait_for_digests();
	endtask

	task automatic test_backpressure();
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		rx_hold = HOLD_CYCLES;
		for (int i = 0; i < 4; i++) send_message(i);
		wait_for_digests();
	endtask

	task automatic test_random_messages();
		int start_items;
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			send_message(int'($urandom_range(0, 12)));
		end
		wait_for_digests();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = KIND_APPEND;
		hash_restart();
		for (int i = 0; i < 16; i++) msg_blk[i] = 32'h0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pad_boundaries();
		test_backpressure();
		test_random_messages();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && digest_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
